// ----- hdl/fsb_pkg.sv -----
// Shared types and codes for the frame store sprite blitter.
`timescale 1ns / 1ps

package fsb_pkg;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_DATA  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        OP_COPY   = 2'd0,
        OP_XOR    = 2'd1,
        OP_ANDNOT = 2'd2,
        OP_CLEAR  = 2'd3
    } raster_op_t;

    localparam logic RESULT_DONE = 1'b0;
    localparam logic RESULT_READ = 1'b1;

    typedef struct packed {
        logic clear_wr;
        logic start;
        logic data_rd;
        logic byte_rd;
        logic write;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic empty_start;
        logic last_byte;
        logic clear_last;
        logic out_free;
    } status_t;

endpackage

// ----- hdl/framebuffer_sprite_blitter.sv -----
// Top level of the frame store sprite blitter: controller and datapath.
//
// Channel  Direction  Handshake         Payload
// in       request    in_valid/in_stall func, raster_op, row, byte_column,
//                                       sprite_width, sprite_height, pixel_byte
// out      result     out_valid/out_stall result_kind, read_value, overlap_bits
//
// A start request is handled on acceptance; a sprite data byte reads the store on
// acceptance and writes the combined byte back in the write state. A read request, an
// empty start and the last data byte of a sprite then pass the emit state, which loads the
// output register; it repeats while an earlier stalled result still holds the register.
// After reset a clearing pass writes zeros to all FRAME_ROWS * ROW_BYTES bytes, one per
// cycle, and no request is taken.
`timescale 1ns / 1ps

module framebuffer_sprite_blitter
    import fsb_pkg::*;
#(
    parameter int FRAME_ROWS = 224,
    parameter int ROW_BYTES  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [1:0] raster_op,
    input  logic [7:0] row,
    input  logic [4:0] byte_column,
    input  logic [5:0] sprite_width,
    input  logic [7:0] sprite_height,
    input  logic [7:0] pixel_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       result_kind,
    output logic [7:0] read_value,
    output logic [7:0] overlap_bits
);

    cmd_t    cmd;
    status_t status;

    fsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    fsb_datapath #(
        .FRAME_ROWS (FRAME_ROWS),
        .ROW_BYTES  (ROW_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .raster_op     (raster_op),
        .row           (row),
        .byte_column   (byte_column),
        .sprite_width  (sprite_width),
        .sprite_height (sprite_height),
        .pixel_byte    (pixel_byte),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .result_kind   (result_kind),
        .read_value    (read_value),
        .overlap_bits  (overlap_bits)
    );

endmodule

// ----- hdl/fsb_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module fsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 7168,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/fsb_ctrl.sv -----
// Controller state machine: clearing pass, request decode and result hand-off.
`timescale 1ns / 1ps

module fsb_ctrl
    import fsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] func,
    input  status_t    status,
    output logic       in_stall,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.clear_wr = (state_reg == S_CLEAR);
        cmd.start    = accept && (func == FUNC_START);
        cmd.data_rd  = accept && (func == FUNC_DATA) && status.active;
        cmd.byte_rd  = accept && (func == FUNC_READ);
        cmd.write    = (state_reg == S_WRITE);
        cmd.emit     = (state_reg == S_EMIT) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                priority if (cmd.start && status.empty_start)
                begin
                    state_next = S_EMIT;
                end
                else if (cmd.data_rd)
                begin
                    state_next = S_WRITE;
                end
                else if (cmd.byte_rd)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WRITE:
            begin
                state_next = status.last_byte ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_data_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.data_rd |=> state_reg == S_WRITE)
        else $error("data byte read not followed by its write cycle");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !(cmd.start || cmd.data_rd || cmd.byte_rd))
        else $error("request taken during the clearing pass");

endmodule

// ----- hdl/fsb_datapath.sv -----
// Datapath: sprite pointer and counters, raster operation, frame store and result register.
`timescale 1ns / 1ps

module fsb_datapath
    import fsb_pkg::*;
#(
    parameter int FRAME_ROWS = 224,
    parameter int ROW_BYTES  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    status,
    input  logic [1:0] raster_op,
    input  logic [7:0] row,
    input  logic [4:0] byte_column,
    input  logic [5:0] sprite_width,
    input  logic [7:0] sprite_height,
    input  logic [7:0] pixel_byte,
    input  logic       out_stall,
    output logic       out_valid,
    output logic       result_kind,
    output logic [7:0] read_value,
    output logic [7:0] overlap_bits
);

    localparam int STORE_SIZE = FRAME_ROWS * ROW_BYTES;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int PTR_MAX    = 510 * ROW_BYTES + 94;
    localparam int PTR_W      = $clog2(PTR_MAX + 1);

    logic [PTR_W-1:0]  ptr_reg;
    logic [5:0]        left_reg;
    logic [7:0]        rows_reg;
    logic [5:0]        width_reg;
    logic [1:0]        op_reg;
    logic [7:0]        acc_reg;
    logic              active_reg;
    logic [7:0]        pix_reg;
    logic              rd_ok_reg;
    logic              pend_kind_reg;
    logic [7:0]        pend_ov_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [7:0]        out_value_reg;
    logic [7:0]        out_ov_reg;

    logic [PTR_W-1:0]  in_addr;
    logic              in_ok;
    logic              ptr_ok;
    logic [7:0]        rdata;
    logic [7:0]        new_byte;
    logic [7:0]        acc_next;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;

    assign in_addr = PTR_W'(row) * PTR_W'(ROW_BYTES) + PTR_W'(byte_column);
    assign in_ok   = in_addr < PTR_W'(STORE_SIZE);
    assign ptr_ok  = ptr_reg < PTR_W'(STORE_SIZE);

    always_comb
    begin
        unique case (op_reg)
            OP_COPY:   new_byte = pix_reg;
            OP_XOR:    new_byte = rdata ^ pix_reg;
            OP_ANDNOT: new_byte = rdata & ~pix_reg;
            OP_CLEAR:  new_byte = 8'd0;
            default:   new_byte = 8'd0;
        endcase
    end

    assign acc_next = (ptr_ok && (op_reg == OP_XOR)) ? (acc_reg | new_byte) : acc_reg;

    assign ram_we    = cmd.clear_wr || (cmd.write && ptr_ok);
    assign ram_waddr = cmd.clear_wr ? clr_cnt_reg : ptr_reg[ADDR_W-1:0];
    assign ram_wdata = cmd.clear_wr ? 8'd0 : new_byte;
    assign ram_re    = cmd.data_rd || (cmd.byte_rd && in_ok);
    assign ram_raddr = cmd.data_rd ? ptr_reg[ADDR_W-1:0] : in_addr[ADDR_W-1:0];

    fsb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        status             = '0;
        status.active      = active_reg;
        status.empty_start = (sprite_width == 6'd0) || (sprite_height == 8'd0);
        status.last_byte   = (left_reg == 6'd1) && (rows_reg == 8'd1);
        status.clear_last  = (clr_cnt_reg == ADDR_W'(STORE_SIZE - 1));
        status.out_free    = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            left_reg      <= '0;
            rows_reg      <= '0;
            width_reg     <= '0;
            op_reg        <= OP_COPY;
            acc_reg       <= '0;
            active_reg    <= 1'b0;
            rd_ok_reg     <= 1'b0;
            pend_kind_reg <= RESULT_DONE;
            pend_ov_reg   <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.start)
            begin
                ptr_reg       <= in_addr;
                width_reg     <= sprite_width;
                op_reg        <= raster_op;
                left_reg      <= sprite_width;
                rows_reg      <= sprite_height;
                acc_reg       <= '0;
                active_reg    <= !status.empty_start;
                pend_kind_reg <= RESULT_DONE;
                pend_ov_reg   <= '0;
            end
            if (cmd.byte_rd)
            begin
                rd_ok_reg     <= in_ok;
                pend_kind_reg <= RESULT_READ;
            end
            if (cmd.write)
            begin
                acc_reg <= acc_next;
                if (left_reg == 6'd1)
                begin
                    rows_reg <= rows_reg - 8'd1;
                    if (rows_reg == 8'd1)
                    begin
                        ptr_reg       <= ptr_reg + PTR_W'(1);
                        left_reg      <= '0;
                        active_reg    <= 1'b0;
                        pend_kind_reg <= RESULT_DONE;
                        pend_ov_reg   <= (op_reg == OP_XOR) ? acc_next : 8'd0;
                    end
                    else
                    begin
                        left_reg <= width_reg;
                        ptr_reg  <= ptr_reg + PTR_W'(1) + PTR_W'(ROW_BYTES)
                                    - PTR_W'(width_reg);
                    end
                end
                else
                begin
                    left_reg <= left_reg - 6'd1;
                    ptr_reg  <= ptr_reg + PTR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data_rd)
        begin
            pix_reg <= pixel_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg  <= pend_kind_reg;
            out_value_reg <= (pend_kind_reg == RESULT_READ && rd_ok_reg) ? rdata : 8'd0;
            out_ov_reg    <= (pend_kind_reg == RESULT_READ) ? 8'd0 : pend_ov_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign read_value   = out_value_reg;
    assign overlap_bits = out_ov_reg;

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> $past(cmd.data_rd))
        else $error("store write without the matching read");

    a_counts_live: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (left_reg != 6'd0) && (rows_reg != 8'd0))
        else $error("active sprite with an exhausted counter");

    a_idle_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> $past(cmd.write || cmd.start))
        else $error("sprite ended without a last byte or a restart");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("result lost at the output register");

endmodule

// ----- tb/tb_framebuffer_sprite_blitter.sv -----
// Testbench for the frame store sprite blitter: shadow-store prediction and result checking.
`timescale 1ns / 1ps

module tb_framebuffer_sprite_blitter
    import fsb_pkg::*;
();

    localparam int FRAME_ROWS  = 224;
    localparam int ROW_BYTES   = 32;
    localparam int STORE_BYTES = FRAME_ROWS * ROW_BYTES;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic [7:0] overlap;
    } result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] func;
    logic [1:0] raster_op;
    logic [7:0] row;
    logic [4:0] byte_column;
    logic [5:0] sprite_width;
    logic [7:0] sprite_height;
    logic [7:0] pixel_byte;
    logic       out_valid;
    logic       out_stall;
    logic       result_kind;
    logic [7:0] read_value;
    logic [7:0] overlap_bits;

    logic [7:0] shadow_store [0:STORE_BYTES-1];
    int         blit_ptr;
    int         bytes_left;
    int         rows_left;
    int         held_width;
    raster_op_t held_op;
    logic [7:0] overlap_acc;
    logic       sprite_busy;

    result_t    results_due [$];
    int         mismatches;
    int         requests_sent;
    int         results_checked;
    logic       sender_idling;
    logic       receiver_idling;

    framebuffer_sprite_blitter #(
        .FRAME_ROWS(FRAME_ROWS),
        .ROW_BYTES (ROW_BYTES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .raster_op    (raster_op),
        .row          (row),
        .byte_column  (byte_column),
        .sprite_width (sprite_width),
        .sprite_height(sprite_height),
        .pixel_byte   (pixel_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .read_value   (read_value),
        .overlap_bits (overlap_bits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void expect_result(logic kind, logic [7:0] value, logic [7:0] overlap);
        result_t r;
        r.kind    = kind;
        r.value   = value;
        r.overlap = overlap;
        results_due.push_back(r);
    endfunction

    function automatic void apply_to_shadow_store(func_t f, raster_op_t op, logic [7:0] r,
                                                  logic [4:0] c, logic [5:0] w, logic [7:0] h,
                                                  logic [7:0] pix);
        int         addr;
        logic [7:0] merged;
        addr = int'(r) * ROW_BYTES + int'(c);
        case (f)
            FUNC_START:
            begin
                blit_ptr    = addr;
                held_width  = int'(w);
                held_op     = op;
                bytes_left  = int'(w);
                rows_left   = int'(h);
                overlap_acc = 8'd0;
                if (w == 0 || h == 0)
                begin
                    sprite_busy = 1'b0;
                    expect_result(RESULT_DONE, 8'd0, 8'd0);
                end
                else
                begin
                    sprite_busy = 1'b1;
                end
            end
            FUNC_DATA:
            begin
                if (sprite_busy)
                begin
                    if (blit_ptr < STORE_BYTES)
                    begin
                        case (held_op)
                            OP_COPY:   merged = pix;
                            OP_XOR:    merged = shadow_store[blit_ptr] ^ pix;
                            OP_ANDNOT: merged = shadow_store[blit_ptr] & ~pix;
                            default:   merged = 8'd0;
                        endcase
                        shadow_store[blit_ptr] = merged;
                        if (held_op == OP_XOR)
                            overlap_acc = overlap_acc | merged;
                    end
                    blit_ptr++;
                    bytes_left--;
                    if (bytes_left == 0)
                    begin
                        rows_left--;
                        if (rows_left == 0)
                        begin
                            sprite_busy = 1'b0;
                            expect_result(RESULT_DONE, 8'd0,
                                          (held_op == OP_XOR) ? overlap_acc : 8'd0);
                        end
                        else
                        begin
                            bytes_left = held_width;
                            blit_ptr   = blit_ptr - held_width + ROW_BYTES;
                        end
                    end
                end
            end
            FUNC_READ:
            begin
                expect_result(RESULT_READ, (addr < STORE_BYTES) ? shadow_store[addr] : 8'd0,
                              8'd0);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [7:0] want, logic [7:0] got);
        $display("%0t: mismatch on %s: expected 0x%02h, got 0x%02h", $time, field, want, got);
        mismatches++;
    endtask

    task automatic send_request(func_t f, raster_op_t op, logic [7:0] r, logic [4:0] c,
                                logic [5:0] w, logic [7:0] h, logic [7:0] pix);
        if (sender_idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        raster_op     <= op;
        row           <= r;
        byte_column   <= c;
        sprite_width  <= w;
        sprite_height <= h;
        pixel_byte    <= pix;
        do
            @(posedge clk);
        while (in_stall);
        apply_to_shadow_store(f, op, r, c, w, h, pix);
        requests_sent++;
    endtask

    task automatic send_start(raster_op_t op, logic [7:0] r, logic [4:0] c, logic [5:0] w,
                              logic [7:0] h);
        send_request(FUNC_START, op, r, c, w, h, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_data(logic [7:0] pix);
        send_request(FUNC_DATA, raster_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)), pix);
    endtask

    task automatic send_read(logic [7:0] r, logic [4:0] c);
        send_request(FUNC_READ, raster_op_t'($urandom_range(0, 3)), r, c,
                     6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
    endtask

    task automatic send_unused();
        send_request(FUNC_NONE, raster_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_cleared_store();
        send_read(8'd0, 5'd0);
        send_read(8'd223, 5'd31);
    endtask

    task automatic test_empty_sprite();
        send_start(OP_XOR, 8'd12, 5'd3, 6'd0, 8'd5);
        send_start(OP_COPY, 8'd12, 5'd3, 6'd3, 8'd0);
    endtask

    task automatic test_raster_ops();
        send_start(OP_COPY, 8'd10, 5'd4, 6'd2, 8'd1);
        send_data(8'hFF);
        send_data(8'hA5);
        send_start(OP_XOR, 8'd10, 5'd4, 6'd2, 8'd1);
        send_data(8'h0F);
        send_data(8'hFF);
        send_start(OP_ANDNOT, 8'd10, 5'd4, 6'd1, 8'd1);
        send_data(8'h3C);
        send_read(8'd10, 5'd4);
        send_start(OP_CLEAR, 8'd10, 5'd5, 6'd1, 8'd1);
        send_data(8'hFF);
        send_read(8'd10, 5'd5);
    endtask

    task automatic test_edge_cases();
        // Data while idle and the unused function code must both be ignored.
        send_data(8'h81);
        send_unused();
        // The largest rectangle is started and then abandoned by a new start.
        send_start(OP_CLEAR, 8'd255, 5'd31, 6'd63, 8'd255);
        send_data(8'h55);
        send_start(OP_COPY, 8'd5, 5'd31, 6'd2, 8'd1);
        send_data(8'hC3);
        send_read(8'd5, 5'd31);
        send_data(8'h7E);
        send_read(8'd6, 5'd0);
        // An xor sprite that runs off the end of the store.
        send_start(OP_XOR, 8'd223, 5'd31, 6'd2, 8'd1);
        send_data(8'hF0);
        send_data(8'hFF);
        send_read(8'd255, 5'd31);
    endtask

    task automatic blit_random_sprite(int max_w, int max_h);
        raster_op_t op;
        int         w;
        int         h;
        int         r;
        int         c;
        int         stop_at;
        op = raster_op_t'($urandom_range(0, 3));
        w  = $urandom_range(1, max_w);
        h  = $urandom_range(1, max_h);
        r  = ($urandom_range(0, 15) == 0) ? $urandom_range(220, 255) : $urandom_range(0, 223);
        c  = $urandom_range(0, 31);
        if ($urandom_range(0, 29) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                w = 0;
            else
                h = 0;
        end
        send_start(op, 8'(r), 5'(c), 6'(w), 8'(h));
        stop_at = w * h;
        if (stop_at > 1 && $urandom_range(0, 19) == 0)
            stop_at = $urandom_range(0, stop_at - 1);
        for (int n = 0; n < stop_at; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_read(8'(r + $urandom_range(0, 3)), 5'(c + $urandom_range(0, 3)));
            if ($urandom_range(0, 49) == 0)
                send_unused();
            send_data(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            send_data(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2))
            send_read(8'(r + $urandom_range(0, 3)), 5'(c + $urandom_range(0, 3)));
    endtask

    task automatic test_random_sprites(int count);
        int target;
        target = requests_sent + count;
        while (requests_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_read(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            blit_random_sprite(4, 4);
        end
    endtask

    task automatic test_large_sprites();
        send_start(OP_COPY, 8'd100, 5'd31, 6'd40, 8'd2);
        repeat (80) send_data(8'($urandom_range(0, 255)));
        send_read(8'd101, 5'd15);
        send_start(OP_XOR, 8'd30, 5'd7, 6'd1, 8'd200);
        repeat (200) send_data(8'($urandom_range(0, 255)));
        send_read(8'd129, 5'd7);
        send_start(OP_XOR, 8'd223, 5'd0, 6'd63, 8'd1);
        repeat (63) send_data(8'($urandom_range(0, 255)));
    endtask

    task automatic test_drain_pause();
        repeat (4) blit_random_sprite(3, 3);
        wait_for_drain();
        send_read(8'd30, 5'd7);
        blit_random_sprite(2, 2);
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result arrived with none expected", $time);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                results_checked++;
                if (result_kind !== want.kind)
                    report_mismatch("result_kind", 8'(want.kind), 8'(result_kind));
                if (read_value !== want.value)
                    report_mismatch("read_value", want.value, read_value);
                if (overlap_bits !== want.overlap)
                    report_mismatch("overlap_bits", want.overlap, overlap_bits);
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (receiver_idling && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        func            = FUNC_NONE;
        raster_op       = OP_COPY;
        row             = 8'd0;
        byte_column     = 5'd0;
        sprite_width    = 6'd0;
        sprite_height   = 8'd0;
        pixel_byte      = 8'd0;
        mismatches      = 0;
        requests_sent   = 0;
        results_checked = 0;
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        blit_ptr        = 0;
        bytes_left      = 0;
        rows_left       = 0;
        held_width      = 0;
        held_op         = OP_COPY;
        overlap_acc     = 8'd0;
        sprite_busy     = 1'b0;
        for (int i = 0; i < STORE_BYTES; i++)
            shadow_store[i] = 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_store();
        test_empty_sprite();
        test_raster_ops();
        test_edge_cases();
        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
        test_random_sprites(600);
        test_large_sprites();
        test_drain_pause();
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        test_random_sprites(250);

        wait_for_drain();
        repeat (20) @(posedge clk);
        $display("Ran %0d requests and checked %0d results: all raster ops, empty, abandoned",
                 requests_sent, results_checked);
        $display("and off-store sprites, column wrap, reads mid-sprite, with random idling.");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
